// ===== rtl/pfd_pkg.sv =====
package pfd_pkg;

	// Byte codes of the sensor protocol.
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_O = 8'h4F;
	localparam logic [7:0] CH_UPPER_T = 8'h54;
	localparam logic [7:0] CH_UPPER_K = 8'h4B;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_UPPER_Y = 8'h59;
	localparam logic [7:0] CH_LOWER_T = 8'h74;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	localparam logic [15:0] TIMEOUT_RESET = 16'd200;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEAD   = 3'd1,
		PH_BODY   = 3'd2,
		PH_TRAIL1 = 3'd3,
		PH_TRAIL2 = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EM_IDLE = 2'd0,
		EM_READ = 2'd1,
		EM_SHOW = 2'd2
	} emit_state_t;

	// Events handed to the link monitor for one processed word.
	typedef struct packed {
		logic tick;
		logic rx_byte;
	} pfd_event_t;

	// Link monitor status: registered value and the value after this word.
	typedef struct packed {
		logic alive_d;
		logic alive_q;
	} pfd_link_t;

endpackage

// ===== rtl/pfd_link.sv =====
module pfd_link import pfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic [15:0] cfg_data,
	input  pfd_event_t  ev,
	input  logic        ready,
	output pfd_link_t   link
);

	logic [15:0] timeout_q;
	logic [15:0] idle_q;
	logic [15:0] idle_d;
	logic        alive_q;
	logic        alive_d;

	// Ticks count up and saturate; any received byte restarts the count.
	always_comb begin
		idle_d  = idle_q;
		alive_d = alive_q;
		if (ev.tick) begin
			if (idle_q != 16'hFFFF) begin
				idle_d = idle_q + 16'd1;
			end
			if (ready && (idle_d >= timeout_q)) begin
				alive_d = 1'b0;
			end
		end else if (ev.rx_byte) begin
			idle_d  = '0;
			alive_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			idle_q    <= '0;
			alive_q   <= 1'b1;
		end else begin
			if (cfg_wr) begin
				timeout_q <= cfg_data;
			end
			idle_q  <= idle_d;
			alive_q <= alive_d;
		end
	end

	assign link.alive_d = alive_d;
	assign link.alive_q = alive_q;

endmodule

// ===== rtl/position_frame_deframer_top.sv =====
// Position frame deframer.
// The input channel (in_valid, in_stall, kind, data_byte) carries one word per
// item: either a received serial byte or one time tick. The output channel
// (out_valid, out_stall and the result fields) carries status words and, after
// a good frame once the block is ready, the frame payload as little-endian
// 32-bit words with the final one marked by last. The configuration channel
// (cfg_valid, cfg_ready, cfg_data) writes the tick timeout and is always ready.
// An accepted item is registered in an input stage. Once the output register
// is free, the item leaves that stage and its status word is loaded into the
// output register, or at a good frame end the payload read starts. The input
// stage holds one item at a time and takes no new item while it is occupied.
// A good frame end reads the payload memory word by word: each of the
// PAYLOAD_BYTES/4 words is read in EM_READ and presented in EM_SHOW once the
// output is free, and no new item is accepted until the last one is shown.
// If the receiver stalls, the output register holds its word; one more input
// item is still taken into the input stage and waits there.
// Reset clears the parser to the hunt state, clears all sticky flags, sets
// link_alive, zeroes the idle tick count and loads a timeout of 200 ticks.
// The payload memory is not cleared; it is read only after a full frame.
module position_frame_deframer_top import pfd_pkg::*; #(
	parameter int PAYLOAD_BYTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_word,
	output logic [31:0] payload_word,
	output logic [3:0]  word_index,
	output logic        last,
	output logic        talk_ok,
	output logic        x_set_ack,
	output logic        y_set_ack,
	output logic        angle_set_ack,
	output logic        link_alive,
	output logic        ready_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int NW     = PAYLOAD_BYTES / 4;
	localparam int STORED = NW * 4;
	localparam int CNT_W  = $clog2(PAYLOAD_BYTES);
	localparam int AW     = $clog2(NW);

	// Input stage.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// Parser state.
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             lead_o_q, lead_o_d;
	logic             w0nz_q, w0nz_d;
	logic             talk_q, talk_d;
	logic [2:0]       axis_q, axis_d;
	logic             ready_q, ready_d;

	// Emit sequencer.
	emit_state_t   emit_q, emit_d;
	logic [AW-1:0] idx_q, idx_d;
	logic          emit_busy;
	logic          emit_go;
	logic          last_word;
	logic          load_word;
	logic          load_status;

	// Payload memory, one 32-bit word per four payload bytes.
	logic [31:0]   store_mem [NW];
	logic [31:0]   rd_word_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [1:0]    wr_lane;
	logic          rd_en;

	logic       out_free;
	logic       proc;
	logic       nz;
	pfd_event_t ev;
	pfd_link_t  link;

	// Output register.
	logic        out_valid_q;
	logic        is_word_q;
	logic [31:0] payload_word_q;
	logic [3:0]  word_index_q;
	logic        last_q;
	logic        talk_ok_q;
	logic [2:0]  axis_out_q;
	logic        alive_out_q;
	logic        ready_out_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_busy = (emit_q != EM_IDLE);
	assign in_stall  = valid_s1 || emit_busy;
	assign proc      = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	// Frame parser. Bytes of the frame body go straight into the memory;
	// the nonzero test on word 0 is tracked as its bytes go by, so the ready
	// decision at the trailer needs no memory read.
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		lead_o_d = lead_o_q;
		w0nz_d   = w0nz_q;
		talk_d   = talk_q;
		axis_d   = axis_q;
		ready_d  = ready_q;
		wr_en    = 1'b0;
		emit_go  = 1'b0;
		nz       = 1'b0;
		if (proc && !kind_s1) begin
			case (phase_q)
				PH_HUNT: begin
					if ((byte_s1 == CH_UPPER_A) || (byte_s1 == CH_UPPER_O)) begin
						lead_o_d = (byte_s1 == CH_UPPER_O);
						phase_d  = PH_LEAD;
					end
				end
				PH_LEAD: begin
					phase_d = PH_HUNT;
					if (byte_s1 == CH_UPPER_T) begin
						cnt_d   = '0;
						w0nz_d  = 1'b0;
						phase_d = PH_BODY;
					end else if (byte_s1 inside {CH_UPPER_K, CH_UPPER_A,
							CH_UPPER_X, CH_UPPER_Y}) begin
						talk_d = 1'b1;
						if (lead_o_q) begin
							if (byte_s1 == CH_UPPER_X) axis_d[0] = 1'b1;
							if (byte_s1 == CH_UPPER_Y) axis_d[1] = 1'b1;
							if (byte_s1 == CH_UPPER_A) axis_d[2] = 1'b1;
						end
					end
				end
				PH_BODY: begin
					wr_en = ({1'b0, cnt_q} < (CNT_W + 1)'(STORED));
					if (cnt_q < CNT_W'(4)) begin
						// Bit 31 of word 0 does not count toward the test.
						nz     = (cnt_q == CNT_W'(3)) ? (|byte_s1[6:0]) : (|byte_s1);
						w0nz_d = w0nz_q | nz;
					end
					if (cnt_q == CNT_W'(PAYLOAD_BYTES - 1)) begin
						cnt_d   = '0;
						phase_d = PH_TRAIL1;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
				PH_TRAIL1: begin
					phase_d = (byte_s1 == CH_LOWER_T) ? PH_TRAIL2 : PH_HUNT;
				end
				PH_TRAIL2: begin
					phase_d = PH_HUNT;
					if ((byte_s1 == CH_LOWER_A) && (ready_q || w0nz_q)) begin
						ready_d = 1'b1;
						emit_go = 1'b1;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			cnt_q    <= '0;
			lead_o_q <= 1'b0;
			w0nz_q   <= 1'b0;
			talk_q   <= 1'b0;
			axis_q   <= '0;
			ready_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			lead_o_q <= lead_o_d;
			w0nz_q   <= w0nz_d;
			talk_q   <= talk_d;
			axis_q   <= axis_d;
			ready_q  <= ready_d;
		end
	end

	assign wr_addr = AW'(cnt_q >> 2);
	assign wr_lane = cnt_q[1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr][{wr_lane, 3'b000} +: 8] <= byte_s1;
		end
		if (rd_en) begin
			rd_word_q <= store_mem[idx_q];
		end
	end

	// Emit sequencer: read a word, then present it once the output is free.
	assign last_word = (idx_q == AW'(NW - 1));
	assign rd_en     = (emit_q == EM_READ);

	always_comb begin
		emit_d    = emit_q;
		idx_d     = idx_q;
		load_word = 1'b0;
		case (emit_q)
			EM_IDLE: begin
				if (emit_go) begin
					emit_d = EM_READ;
					idx_d  = '0;
				end
			end
			EM_READ: begin
				emit_d = EM_SHOW;
			end
			EM_SHOW: begin
				if (out_free) begin
					load_word = 1'b1;
					if (last_word) begin
						emit_d = EM_IDLE;
					end else begin
						idx_d  = idx_q + AW'(1);
						emit_d = EM_READ;
					end
				end
			end
			default: begin
				emit_d = EM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= EM_IDLE;
			idx_q  <= '0;
		end else begin
			emit_q <= emit_d;
			idx_q  <= idx_d;
		end
	end

	// Idle tick counting and the timeout register live in the link monitor.
	assign ev.tick    = proc && kind_s1;
	assign ev.rx_byte = proc && !kind_s1;

	pfd_link u_link (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.ev       (ev),
		.ready    (ready_q),
		.link     (link)
	);

	// A status word carries the flags as they stand after its item. Payload
	// words come while no item is taken, so the registered flags are current.
	assign load_status = proc && !emit_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_status || load_word) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			is_word_q      <= 1'b1;
			payload_word_q <= rd_word_q;
			word_index_q   <= 4'(idx_q);
			last_q         <= last_word;
			talk_ok_q      <= talk_q;
			axis_out_q     <= axis_q;
			alive_out_q    <= link.alive_q;
			ready_out_q    <= ready_q;
		end else if (load_status) begin
			is_word_q      <= 1'b0;
			payload_word_q <= '0;
			word_index_q   <= '0;
			last_q         <= 1'b1;
			talk_ok_q      <= talk_d;
			axis_out_q     <= axis_d;
			alive_out_q    <= link.alive_d;
			ready_out_q    <= ready_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_word       = is_word_q;
	assign payload_word  = payload_word_q;
	assign word_index    = word_index_q;
	assign last          = last_q;
	assign talk_ok       = talk_ok_q;
	assign x_set_ack     = axis_out_q[0];
	assign y_set_ack     = axis_out_q[1];
	assign angle_set_ack = axis_out_q[2];
	assign link_alive    = alive_out_q;
	assign ready_res     = ready_out_q;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfd_pkg::*;

	localparam int PAYLOAD_BYTES = 24;
	localparam int FRAME_WORDS = (PAYLOAD_BYTES / 4 > 16) ? 16 : PAYLOAD_BYTES / 4;
	// A status word shows up after its item passes the input stage and the
	// output register; a good frame end keeps it busy while its words go out.
	localparam int DRAIN_CYCLES = 4 * FRAME_WORDS + 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 8;

	// Fill pattern for the first payload word, which decides readiness.
	typedef enum logic [1:0] {
		W0_FREE,
		W0_ALL_ZERO,
		W0_TOP_ONLY,
		W0_LIVE
	} word0_fill_t;

	// How a frame ends: proper trailer, either trailer byte corrupted, or
	// the body broken off part way.
	typedef enum logic [1:0] {
		TR_GOOD,
		TR_BAD_FIRST,
		TR_BAD_SECOND,
		TR_CUT
	} trailer_kind_t;

	// One output word as the block presents it, in port order.
	typedef struct packed {
		logic        is_word;
		logic [31:0] payload_word;
		logic [3:0]  word_index;
		logic        last;
		logic        talk_ok;
		logic        x_set_ack;
		logic        y_set_ack;
		logic        angle_set_ack;
		logic        link_alive;
		logic        ready_res;
	} deframe_result_t;

	// Directed stimulus row. When pinned is set, the status word that the
	// row causes is typed in here as the flag set {talk, x, y, angle, alive,
	// ready}; otherwise the predictor supplies it.
	typedef struct packed {
		logic       tick;
		logic [7:0] byte_val;
		logic       pinned;
		logic [5:0] flags;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_word;
	logic [31:0] payload_word;
	logic [3:0]  word_index;
	logic        last;
	logic        talk_ok;
	logic        x_set_ack;
	logic        y_set_ack;
	logic        angle_set_ack;
	logic        link_alive;
	logic        ready_res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Travels with the input word so the scoreboard knows, at the edge that
	// takes the word, whether a typed expectation replaces the predicted one.
	logic        row_pinned;
	logic [5:0]  row_flags;

	position_frame_deframer_top #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_word      (is_word),
		.payload_word (payload_word),
		.word_index   (word_index),
		.last         (last),
		.talk_ok      (talk_ok),
		.x_set_ack    (x_set_ack),
		.y_set_ack    (y_set_ack),
		.angle_set_ack(angle_set_ack),
		.link_alive   (link_alive),
		.ready_res    (ready_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Predictor state: the deframer's parser, its payload buffer, the sticky
	// flags and the link watch, all as they stand after reset.
	phase_t      parse_phase = PH_HUNT;
	int          body_count = 0;
	logic        lead_o = 1'b0;
	logic [7:0]  frame_bytes [PAYLOAD_BYTES];
	logic        ready_seen = 1'b0;
	logic        talk_seen = 1'b0;
	logic [2:0]  axis_seen = 3'b000;
	logic        alive_now = 1'b1;
	logic [15:0] idle_count = 16'd0;
	logic [15:0] timeout_cfg = TIMEOUT_RESET;

	deframe_result_t expected_words [$];

	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          items_sent = 0;
	int          ticks_sent = 0;
	int          words_checked = 0;
	int          payload_checked = 0;
	int          fault_count = 0;
	int          quiet_cycles = 0;

	// Appends one predicted output word at the tail of the expected list.
	function automatic void queue_word(input deframe_result_t r);
		expected_words.insert(expected_words.size(), r);
	endfunction

	// Builds one output word around the flags as they stand right now.
	function automatic deframe_result_t flags_word(input logic w, input logic [31:0] v,
			input logic [3:0] idx, input logic fin);
		return {w, v, idx, fin, talk_seen, axis_seen[0], axis_seen[1], axis_seen[2],
			alive_now, ready_seen};
	endfunction

	// Advances the predicted deframer by one input word and queues every
	// output word it causes.
	function automatic void deframe_step(input logic tick, input logic [7:0] b);
		logic        emit;
		logic [31:0] w;
		emit = 1'b0;
		if (tick) begin
			if (idle_count != 16'hFFFF)
				idle_count = idle_count + 16'd1;
			// Link loss is only declared once the sensor has proven itself.
			if (ready_seen && idle_count >= timeout_cfg)
				alive_now = 1'b0;
			queue_word(flags_word(1'b0, 32'd0, 4'd0, 1'b1));
			return;
		end
		alive_now = 1'b1;
		idle_count = 16'd0;
		case (parse_phase)
			PH_HUNT: begin
				if (b == CH_UPPER_A || b == CH_UPPER_O) begin
					lead_o = (b == CH_UPPER_O);
					parse_phase = PH_LEAD;
				end
			end
			PH_LEAD: begin
				if (b == CH_UPPER_T) begin
					body_count = 0;
					parse_phase = PH_BODY;
				end else if (b == CH_UPPER_K || b == CH_UPPER_A || b == CH_UPPER_X ||
						b == CH_UPPER_Y) begin
					// Short reply. Axis acknowledges only count after an 'O' lead.
					talk_seen = 1'b1;
					if (lead_o) begin
						if (b == CH_UPPER_X)
							axis_seen[0] = 1'b1;
						if (b == CH_UPPER_Y)
							axis_seen[1] = 1'b1;
						if (b == CH_UPPER_A)
							axis_seen[2] = 1'b1;
					end
					parse_phase = PH_HUNT;
				end else begin
					// The offending byte is dropped, not retried as a lead.
					parse_phase = PH_HUNT;
				end
			end
			PH_BODY: begin
				frame_bytes[body_count] = b;
				body_count++;
				if (body_count >= PAYLOAD_BYTES) begin
					body_count = 0;
					parse_phase = PH_TRAIL1;
				end
			end
			PH_TRAIL1: begin
				parse_phase = (b == CH_LOWER_T) ? PH_TRAIL2 : PH_HUNT;
			end
			PH_TRAIL2: begin
				parse_phase = PH_HUNT;
				if (b == CH_LOWER_A) begin
					// Readiness needs bits 30:0 of the first word to be nonzero.
					if (!ready_seen && ({frame_bytes[3][6:0], frame_bytes[2], frame_bytes[1],
							frame_bytes[0]} != 31'd0))
						ready_seen = 1'b1;
					emit = ready_seen;
				end
			end
			default: begin
				parse_phase = PH_HUNT;
			end
		endcase
		if (emit && FRAME_WORDS > 0) begin
			for (int wi = 0; wi < FRAME_WORDS; wi++) begin
				w = 32'd0;
				for (int k = 0; k < 4; k++)
					if (wi * 4 + k < PAYLOAD_BYTES)
						w[8*k +: 8] = frame_bytes[wi * 4 + k];
				queue_word(flags_word(1'b1, w, 4'(wi), wi == FRAME_WORDS - 1));
			end
		end else begin
			queue_word(flags_word(1'b0, 32'd0, 4'd0, 1'b1));
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fault_count++;
		end
	endfunction

	// Scoreboard. Everything here is sampled at the rising edge, before any
	// of the nonblocking updates of that edge land, so the handshakes seen
	// are exactly the ones that happened. Configuration and input words are
	// folded into the predictor first, then an output word is checked.
	always @(posedge clk) begin : scoreboard
		deframe_result_t got;
		deframe_result_t want;
		logic            moved;
		moved = 1'b0;
		if (cfg_valid && cfg_ready) begin
			timeout_cfg = cfg_data;
			moved = 1'b1;
		end
		if (in_valid && !in_stall) begin
			deframe_step(kind, data_byte);
			// A pinned row always causes a single status word; its typed
			// value stands in for the predicted one.
			if (row_pinned)
				expected_words[expected_words.size() - 1] =
					{1'b0, 32'd0, 4'd0, 1'b1, row_flags};
			moved = 1'b1;
		end
		if (out_valid && !out_stall) begin
			moved = 1'b1;
			got = {is_word, payload_word, word_index, last, talk_ok, x_set_ack, y_set_ack,
				angle_set_ack, link_alive, ready_res};
			if (expected_words.size() == 0) begin
				$error("output word 0x%0h arrived with nothing expected", got);
				fault_count++;
			end else begin
				want = expected_words[0];
				expected_words.delete(0);
				compare_field("is_word", want.is_word, got.is_word);
				compare_field("payload_word", want.payload_word, got.payload_word);
				compare_field("word_index", want.word_index, got.word_index);
				compare_field("last", want.last, got.last);
				compare_field("talk_ok", want.talk_ok, got.talk_ok);
				compare_field("x_set_ack", want.x_set_ack, got.x_set_ack);
				compare_field("y_set_ack", want.y_set_ack, got.y_set_ack);
				compare_field("angle_set_ack", want.angle_set_ack, got.angle_set_ack);
				compare_field("link_alive", want.link_alive, got.link_alive);
				compare_field("ready_res", want.ready_res, got.ready_res);
				words_checked++;
				if (want.is_word)
					payload_checked++;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		// The watchdog only looks at progress, so long stalls and gaps are
		// fine as long as something moves now and then.
		if (moved)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d words still expected",
				quiet_cycles, expected_words.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one input word, after a random gap, and returns at the edge
	// that takes it. Valid stays up into the next call when no gap is drawn.
	task automatic send_item(input logic tick, input logic [7:0] b, input logic pin,
			input logic [5:0] fl);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= tick;
		data_byte <= b;
		row_pinned <= pin;
		row_flags <= fl;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(1'b0, b, 1'b0, 6'd0);
	endtask

	task automatic send_tick();
		send_item(1'b1, 8'($urandom_range(255)), 1'b0, 6'd0);
		ticks_sent++;
	endtask

	// Sends one data frame: lead, 'T', the payload and a trailer (none when the
	// body is cut short). Now and then a tick slips in between payload bytes,
	// which must not disturb the parser.
	task automatic send_frame(input word0_fill_t fill, input trailer_kind_t trail);
		logic [7:0] b;
		int         body_len;
		body_len = (trail == TR_CUT) ? $urandom_range(PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
		send_byte($urandom_range(1) ? CH_UPPER_O : CH_UPPER_A);
		send_byte(CH_UPPER_T);
		for (int i = 0; i < body_len; i++) begin
			case ($urandom_range(7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom_range(255));
			endcase
			if (i < 4) begin
				case (fill)
					W0_ALL_ZERO: b = 8'h00;
					// Only bit 31 set: nonzero word, but not enough for readiness.
					W0_TOP_ONLY: b = (i == 3) ? 8'h80 : 8'h00;
					W0_LIVE: if (i == 0 && b == 8'h00) b = 8'h01;
					default: ;
				endcase
			end
			if ($urandom_range(99) < 4)
				send_tick();
			send_byte(b);
		end
		case (trail)
			TR_GOOD: begin
				send_byte(CH_LOWER_T);
				send_byte(CH_LOWER_A);
			end
			TR_BAD_FIRST: begin
				do
					b = 8'($urandom_range(255));
				while (b == CH_LOWER_T);
				send_byte(b);
			end
			TR_BAD_SECOND: begin
				send_byte(CH_LOWER_T);
				do
					b = 8'($urandom_range(255));
				while (b == CH_LOWER_A);
				send_byte(b);
			end
			default: ;
		endcase
	endtask

	// Drops valid and waits for the block to go quiet: all expected words
	// home, then a margin for a frame end that may still be in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Per phase: timeout setting, sender gap and receiver stall percentages.
	// The first phase runs with the low extreme of the timeout, the last with
	// the high extreme, which the short tick bursts of a phase never reach.
	logic [15:0] timeout_tab [4] = '{16'd1, 16'd3, 16'd7, 16'hFFFF};
	int unsigned gap_tab [4] = '{0, 66, 0, 15};
	int unsigned stall_tab [4] = '{0, 0, 66, 15};

	initial begin : stimulus
		dir_row_t      dir_rows [22];
		word0_fill_t   fill;
		trailer_kind_t trail;
		int            phase_end;
		int            pick;
		in_valid = 1'b0;
		kind = 1'b0;
		data_byte = 8'h00;
		row_pinned = 1'b0;
		row_flags = 6'd0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		arst_n = 1'b0;

		// Directed part, under the reset timeout and with no idling. It walks
		// the short replies and the bad-byte paths before any frame is seen,
		// so link_alive must hold through ticks.
		dir_rows = '{
			'{1'b1, 8'h00,      1'b1, 6'b000010},
			'{1'b0, 8'h00,      1'b1, 6'b000010},
			'{1'b0, 8'hFF,      1'b1, 6'b000010},
			'{1'b0, CH_UPPER_A, 1'b1, 6'b000010},
			// Wrong byte after a lead; it must not start a new lead, so the
			// 'X' after it falls on the hunt and is ignored.
			'{1'b0, CH_UPPER_O, 1'b1, 6'b000010},
			'{1'b0, CH_UPPER_X, 1'b1, 6'b000010},
			'{1'b0, CH_UPPER_O, 1'b1, 6'b000010},
			'{1'b0, CH_UPPER_K, 1'b1, 6'b100010},
			// An 'A' lead acknowledges talk but never an axis.
			'{1'b0, CH_UPPER_A, 1'b1, 6'b100010},
			'{1'b0, CH_UPPER_X, 1'b0, 6'b000000},
			'{1'b0, CH_UPPER_O, 1'b1, 6'b100010},
			'{1'b0, CH_UPPER_X, 1'b1, 6'b110010},
			'{1'b0, CH_UPPER_O, 1'b1, 6'b110010},
			'{1'b0, CH_UPPER_Y, 1'b1, 6'b111010},
			'{1'b0, CH_UPPER_O, 1'b1, 6'b111010},
			'{1'b0, CH_UPPER_A, 1'b1, 6'b111110},
			'{1'b0, CH_UPPER_A, 1'b0, 6'b000000},
			'{1'b0, CH_UPPER_Y, 1'b0, 6'b000000},
			'{1'b0, CH_LOWER_A, 1'b0, 6'b000000},
			'{1'b1, 8'hFF,      1'b1, 6'b111110},
			'{1'b0, CH_UPPER_O, 1'b0, 6'b000000},
			'{1'b0, 8'h80,      1'b0, 6'b000000}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			send_item(dir_rows[r].tick, dir_rows[r].byte_val, dir_rows[r].pinned,
				dir_rows[r].flags);

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			cfg_valid <= 1'b1;
			cfg_data <= timeout_tab[ph];
			do
				@(posedge clk);
			while (!cfg_ready);
			cfg_valid <= 1'b0;
			send_gap_pct = gap_tab[ph];
			recv_stall_pct = stall_tab[ph];

			if (ph == 0) begin
				// Before readiness, ticks past the timeout leave the link alive,
				// and neither a frame whose low 31 bits of word 0 are zero nor
				// one with a broken trailer may make the block ready. The last
				// frame does, and the ticks after it clear link_alive.
				repeat (3) send_tick();
				send_frame(W0_TOP_ONLY, TR_GOOD);
				send_frame(W0_LIVE, TR_BAD_FIRST);
				send_frame(W0_ALL_ZERO, TR_GOOD);
				send_frame(W0_LIVE, TR_GOOD);
				repeat (2) send_tick();
			end

			// Random part: mostly well-formed frames and replies with random
			// content, mixed with tick bursts, broken frames and stray bytes.
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					case ($urandom_range(9))
						0: fill = W0_ALL_ZERO;
						1: fill = W0_TOP_ONLY;
						2: fill = W0_LIVE;
						default: fill = W0_FREE;
					endcase
					case ($urandom_range(11))
						0: trail = TR_BAD_FIRST;
						1: trail = TR_BAD_SECOND;
						2: trail = TR_CUT;
						default: trail = TR_GOOD;
					endcase
					send_frame(fill, trail);
				end else if (pick < 65) begin
					send_byte($urandom_range(1) ? CH_UPPER_O : CH_UPPER_A);
					case ($urandom_range(4))
						0: send_byte(CH_UPPER_K);
						1: send_byte(CH_UPPER_A);
						2: send_byte(CH_UPPER_X);
						3: send_byte(CH_UPPER_Y);
						default: send_byte(8'($urandom_range(255)));
					endcase
				end else if (pick < 85) begin
					repeat ($urandom_range(1, 8)) send_tick();
				end else begin
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
				end
			end
		end

		settle();
		$display("Run covered %0d input words (%0d ticks) under five timeout settings,",
			items_sent, ticks_sent);
		$display("checking %0d output words, %0d of them frame payload words.",
			words_checked, payload_checked);
		if (fault_count == 0 && expected_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pfd_pkg.sv
rtl/pfd_link.sv
rtl/position_frame_deframer_top.sv
dv/tb_top.sv
